// ===== hdl/dither_nearest_palette_mapper_macros.svh =====
// Assertion macros for the dither nearest-palette mapper.
`ifndef DITHER_NEAREST_PALETTE_MAPPER_MACROS_SVH
`define DITHER_NEAREST_PALETTE_MAPPER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DNPM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dnpm_pkg.sv =====
// Package: constants, command codes and the ordered dither function.
`timescale 1ns / 1ps
package dnpm_pkg;

   localparam int PALETTE_SIZE_DEF = 256;
   localparam int CELL_BITS_DEF    = 5;
   localparam int EPOCH_BITS       = 4;

   typedef enum logic [0:0] {
      CMD_MAP = 1'b0,
      CMD_PAL = 1'b1
   } cmd_type;

   // 4x4 ordered matrix, indexed by {row, column} = {x_phase, y_phase}
   localparam logic signed [4:0] DITH_TAB [16] = '{
      -5'sd7,  5'sd1, -5'sd5,  5'sd3,
       5'sd5, -5'sd3,  5'sd7, -5'sd1,
      -5'sd4,  5'sd4, -5'sd6,  5'sd2,
       5'sd8,  5'sd0,  5'sd6, -5'sd2
   };

   // Add twice the matrix value and clamp to 0..255.
   function automatic logic [7:0] dither_channel(input logic [7:0] ch,
                                                 input logic [1:0] xp,
                                                 input logic [1:0] yp);
      logic signed [4:0] t;
      logic signed [9:0] sum;
      t   = DITH_TAB[{xp, yp}];
      sum = $signed({2'b00, ch}) + $signed({{4{t[4]}}, t, 1'b0});
      if (sum < 0) begin
         return 8'd0;
      end else if (sum > 10'sd255) begin
         return 8'd255;
      end
      return sum[7:0];
   endfunction

endpackage

// ===== hdl/dither_nearest_palette_mapper.sv =====
// Top level: dithering nearest-palette-color mapper with a cell cache.
//
// Input channel req_*: one item per handshake (req_valid high, req_stall low).
//   req_cmd map pixel: one result on rsp_*. req_cmd palette write: stores one
//   entry, drops the whole cell cache, gives no result.
// Result channel rsp_*: rsp_color_index and rsp_cache_hit, held in an output
//   register; while rsp_stall is high the result holds and the block may still
//   accept and work on the next item until it has a new result to hand over.
// Config channel csr_*: dither_mode, always ready; write only while idle.
// Flow: a cache hit goes from the check state straight to done, skipping the
//   search; a miss scans the palette one entry per cycle through the single
//   palette read port before its result goes through done. A palette write
//   is stored as it is accepted.
// Cache invalidation uses an epoch tag per cell; every (2^EPOCH_BITS - 1)-th
//   invalidation, and reset, start a clearing pass over all 2^(3*CELL_BITS) cells
//   (32768 by default) during which req_stall stays high.
// Reset (synchronous, active high): palette reads as all zero, cache empty,
//   dither_mode 0, no result pending.
`timescale 1ns / 1ps
`include "dither_nearest_palette_mapper_macros.svh"
module dither_nearest_palette_mapper #(
   parameter int PALETTE_SIZE = dnpm_pkg::PALETTE_SIZE_DEF,
   parameter int CELL_BITS    = dnpm_pkg::CELL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [0:0] req_cmd,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_entry_index,
   input  logic [1:0] req_x_phase,
   input  logic [1:0] req_y_phase,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_color_index,
   output logic       rsp_cache_hit,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_dither_mode
);

   localparam int IDX_BITS   = $clog2(PALETTE_SIZE);
   localparam int CNT_BITS   = $clog2(PALETTE_SIZE + 2);
   localparam int CELL_ABITS = 3 * CELL_BITS;
   localparam int CELL_COUNT = 1 << CELL_ABITS;
   localparam int EB         = dnpm_pkg::EPOCH_BITS;
   localparam int CW         = EB + 8;
   localparam logic [CNT_BITS-1:0] CNT_LAST  = CNT_BITS'(PALETTE_SIZE - 1);
   localparam logic [CNT_BITS-1:0] CNT_END   = CNT_BITS'(PALETTE_SIZE + 1);
   localparam logic [EB-1:0]       EPOCH_MAX = {EB{1'b1}};
   localparam logic [EB-1:0]       EPOCH_ONE = EB'(1);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_LOOK   = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_SEARCH = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CELL_ABITS-1:0] clr_addr_ff, clr_addr_in;
   logic [EB-1:0]         epoch_ff, epoch_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  mode_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_idx_ff;
   logic                  rsp_hit_ff;

   logic [7:0] pix_r_ff, pix_g_ff, pix_b_ff;
   logic [7:0] res_idx_ff;
   logic       res_hit_ff;

   logic [23:0]           pal_mem [PALETTE_SIZE];
   logic [PALETTE_SIZE-1:0] pal_valid_ff;
   logic [23:0]           pal_rd_ff;
   logic                  pal_ok_ff;

   logic [CW-1:0]         cache_mem [CELL_COUNT];
   logic [CW-1:0]         cache_rd_ff;

   logic                  s1_vld_ff, s2_vld_ff;
   logic [IDX_BITS-1:0]   s1_idx_ff, s2_idx_ff;
   logic [15:0]           sq_r_ff, sq_g_ff, sq_b_ff;
   logic                  best_have_ff;
   logic [17:0]           best_dist_ff;
   logic [IDX_BITS-1:0]   best_idx_ff;

   logic                  req_accept, pal_inv, slot_ok, cache_hit_w, rsp_load;
   logic                  cache_we;
   logic [CELL_ABITS-1:0] cell_w, cache_waddr;
   logic [CW-1:0]         cache_wdata;
   logic [7:0]            done_idx;
   logic [7:0]            pr, pg, pb, dr, dg, db;
   logic [17:0]           dist_w;
   logic [IDX_BITS-1:0]   slot_w, rd_addr;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign slot_ok    = ({1'b0, req_entry_index} < 9'(PALETTE_SIZE));
   assign slot_w     = req_entry_index[IDX_BITS-1:0];
   assign pal_inv    = req_accept && (req_cmd == dnpm_pkg::CMD_PAL) && slot_ok;
   assign cell_w     = {pix_r_ff[7 -: CELL_BITS], pix_g_ff[7 -: CELL_BITS],
                        pix_b_ff[7 -: CELL_BITS]};
   assign cache_hit_w = (cache_rd_ff[CW-1 -: EB] == epoch_ff);
   assign done_idx    = res_hit_ff ? res_idx_ff : 8'(best_idx_ff);
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rd_addr     = cnt_ff[IDX_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      epoch_in     = epoch_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CELL_ABITS'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pal_inv) begin
               if (epoch_ff == EPOCH_MAX) begin
                  epoch_in    = EPOCH_ONE;
                  clr_addr_in = '0;
                  state_in    = ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
               end
            end else if (req_accept && (req_cmd == dnpm_pkg::CMD_MAP)) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cnt_in   = '0;
            state_in = cache_hit_w ? ST_DONE : ST_SEARCH;
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_END) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         epoch_ff     <= EPOCH_ONE;
         cnt_ff       <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pal_valid_ff <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         best_have_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         epoch_ff     <= epoch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_dither_mode;
         end
         if (pal_inv) begin
            pal_valid_ff[slot_w] <= 1'b1;
         end
         s1_vld_ff <= (state_ff == ST_SEARCH) && (cnt_ff <= CNT_LAST);
         s2_vld_ff <= s1_vld_ff;
         // restart the minimum at the start of every scan
         if (state_ff == ST_CHECK) begin
            best_have_ff <= 1'b0;
         end else if (s2_vld_ff) begin
            best_have_ff <= 1'b1;
         end
      end
   end

   // Pixel capture with optional dither
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_r_ff <= mode_ff ? dnpm_pkg::dither_channel(req_red, req_x_phase, req_y_phase)
                             : req_red;
         pix_g_ff <= mode_ff ? dnpm_pkg::dither_channel(req_green, req_x_phase, req_y_phase)
                             : req_green;
         pix_b_ff <= mode_ff ? dnpm_pkg::dither_channel(req_blue, req_x_phase, req_y_phase)
                             : req_blue;
      end
      if (state_ff == ST_CHECK) begin
         res_idx_ff <= cache_rd_ff[7:0];
         res_hit_ff <= cache_hit_w;
      end
      if (rsp_load) begin
         rsp_idx_ff <= done_idx;
         rsp_hit_ff <= res_hit_ff;
      end
   end

   // Palette memory: written on palette item, scanned during a miss
   always_ff @(posedge clock) begin
      if (pal_inv) begin
         pal_mem[slot_w] <= {req_red, req_green, req_blue};
      end
      pal_rd_ff <= pal_mem[rd_addr];
      pal_ok_ff <= pal_valid_ff[rd_addr];
      s1_idx_ff <= rd_addr;
   end

   // Distance pipeline: squares, then sum and compare
   always_comb begin
      pr = pal_ok_ff ? pal_rd_ff[23:16] : 8'd0;
      pg = pal_ok_ff ? pal_rd_ff[15:8]  : 8'd0;
      pb = pal_ok_ff ? pal_rd_ff[7:0]   : 8'd0;
      dr = (pr > pix_r_ff) ? (pr - pix_r_ff) : (pix_r_ff - pr);
      dg = (pg > pix_g_ff) ? (pg - pix_g_ff) : (pix_g_ff - pg);
      db = (pb > pix_b_ff) ? (pb - pix_b_ff) : (pix_b_ff - pb);
      dist_w = 18'(sq_r_ff) + 18'(sq_g_ff) + 18'(sq_b_ff);
   end

   always_ff @(posedge clock) begin
      sq_r_ff   <= dr * dr;
      sq_g_ff   <= dg * dg;
      sq_b_ff   <= db * db;
      s2_idx_ff <= s1_idx_ff;
      // first minimum wins: replace only on strictly smaller
      if (s2_vld_ff && (!best_have_ff || (dist_w < best_dist_ff))) begin
         best_dist_ff <= dist_w;
         best_idx_ff  <= s2_idx_ff;
      end
   end

   // Cell cache: epoch tag plus index; cleared entries carry epoch zero
   always_comb begin
      cache_we    = 1'b0;
      cache_waddr = cell_w;
      cache_wdata = {epoch_ff, done_idx};
      priority if (state_ff == ST_CLEAR) begin
         cache_we    = 1'b1;
         cache_waddr = clr_addr_ff;
         cache_wdata = '0;
      end else if (rsp_load && !res_hit_ff) begin
         cache_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      cache_rd_ff <= cache_mem[cell_w];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_idx_ff;
   assign rsp_cache_hit   = rsp_hit_ff;

   `DNPM_ASSERT_NOW(a_rsp_only_from_done, $rose(rsp_valid_ff), $past(state_ff == ST_DONE), "result appeared outside done state")
   `DNPM_ASSERT_NEXT(a_pal_write_invalidates, pal_inv, (epoch_ff != $past(epoch_ff)) || (state_ff == ST_CLEAR), "palette write did not invalidate cache")
   `DNPM_ASSERT_NEXT(a_hit_goes_done, (state_ff == ST_CHECK) && cache_hit_w, (state_ff == ST_DONE) && res_hit_ff, "cache hit did not skip the search")
   `DNPM_ASSERT_NOW(a_fill_only_on_miss, cache_we && (state_ff != ST_CLEAR), !res_hit_ff, "cache filled on a hit")

endmodule
